/* rtl/etpp_pkg.sv */
// ----------------------------------------------------------------------------
// etpp_pkg
// Shared types and constants of the edge table PWM player: transaction
// structs, command codes and parameter defaults.
// ----------------------------------------------------------------------------
package etpp_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned OFFSET_W = 16;
  localparam int unsigned LEVEL_W  = 5;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned LENGTH_W = 17;

  localparam int unsigned MAX_EDGES_DEF   = 64;
  localparam int unsigned CHANNELS_DEF    = 5;
  localparam int unsigned OFFSET_BITS_DEF = 16;

  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMMIT = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [INDEX_W-1:0]  entry_index;
    logic [OFFSET_W-1:0] entry_offset;
    logic [LEVEL_W-1:0]  entry_levels;
    logic [COUNT_W-1:0]  edge_count;
    logic [LENGTH_W-1:0] cycle_length;
  } item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level_mask;
    logic               edge_applied;
    logic               cycle_wrapped;
    logic               rejected;
  } result_t;

endpackage

/* rtl/etpp_engine.sv */
// ----------------------------------------------------------------------------
// etpp_engine
// Edge table state and player. Both banks of edges live in one synchronous
// RAM, read into a register at the next-state edge index; edge 0 of each bank
// is mirrored in registers so commit and wrap can apply it at once.
// ----------------------------------------------------------------------------
module etpp_engine #(
  parameter int unsigned MAX_EDGES   = etpp_pkg::MAX_EDGES_DEF,
  parameter int unsigned CHANNELS    = etpp_pkg::CHANNELS_DEF,
  parameter int unsigned OFFSET_BITS = etpp_pkg::OFFSET_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  etpp_pkg::item_t  item_i,
  output etpp_pkg::result_t result_o
);

  localparam int unsigned IDX_W  = $clog2(MAX_EDGES);
  localparam int unsigned CNT_W  = $clog2(MAX_EDGES + 1);
  localparam int unsigned LEN_W  = OFFSET_BITS + 1;
  localparam int unsigned ADDR_W = IDX_W + 1;
  localparam int unsigned DEPTH  = 2 ** ADDR_W;
  localparam logic [8:0]  MAX_CNT9 = 9'(MAX_EDGES);
  localparam logic [24:0] MAX_LEN25 = 25'(2 ** OFFSET_BITS);

  typedef struct packed {
    logic [OFFSET_BITS-1:0] off;
    logic [CHANNELS-1:0]    lev;
  } edge_t;

  edge_t mem_q [DEPTH];
  edge_t rd_q;
  edge_t head0_q [2];

  logic [CNT_W-1:0]       cnt_q [2];
  logic [CNT_W-1:0]       cnt_d [2];
  logic [LEN_W-1:0]       len_q [2];
  logic [LEN_W-1:0]       len_d [2];
  logic                   bank_q, bank_d;
  logic                   pend_q, pend_d;
  logic                   run_q, run_d;
  logic [CNT_W-1:0]       ne_q, ne_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [CHANNELS-1:0]    lev_q, lev_d;

  logic                   target;
  logic [8:0]             idx_in, cnt_in, cnt_cl9;
  logic [24:0]            len_in, len_cl25;
  logic [23:0]            off_in;
  logic [7:0]             lev_in, lev_out;
  logic [IDX_W-1:0]       wr_idx;
  logic [LEN_W-1:0]       pos_n;
  edge_t                  wr_data, cand;
  logic                   mem_we, head_we;
  logic [ADDR_W-1:0]      wr_addr, rd_addr;
  logic                   applied, wrapped, rejected;

  assign target   = ~bank_q;
  assign idx_in   = 9'(item_i.entry_index);
  assign wr_idx   = idx_in[IDX_W-1:0];
  assign off_in   = 24'(item_i.entry_offset);
  assign lev_in   = 8'(item_i.entry_levels);
  assign wr_data  = '{off: off_in[OFFSET_BITS-1:0], lev: lev_in[CHANNELS-1:0]};
  assign wr_addr  = {target, wr_idx};
  assign cnt_in   = 9'(item_i.edge_count);
  assign len_in   = 25'(item_i.cycle_length);
  assign cnt_cl9  = (cnt_in == 9'd0) ? 9'd1 : ((cnt_in > MAX_CNT9) ? MAX_CNT9 : cnt_in);
  assign len_cl25 = (len_in == 25'd0) ? 25'd1 : ((len_in > MAX_LEN25) ? MAX_LEN25 : len_in);
  assign rd_addr  = {bank_d, ne_d[IDX_W-1:0]};

  always_comb begin
    cnt_d    = cnt_q;
    len_d    = len_q;
    bank_d   = bank_q;
    pend_d   = pend_q;
    run_d    = run_q;
    ne_d     = ne_q;
    pos_d    = pos_q;
    lev_d    = lev_q;
    mem_we   = 1'b0;
    head_we  = 1'b0;
    applied  = 1'b0;
    wrapped  = 1'b0;
    rejected = 1'b0;
    pos_n    = LEN_W'(pos_q) + LEN_W'(1);
    cand     = rd_q;
    if (accept_i) begin
      unique case (item_i.command)
        etpp_pkg::CMD_WRITE: begin
          if (pend_q) begin
            rejected = 1'b1;
          end else if (idx_in < MAX_CNT9) begin
            mem_we  = 1'b1;
            head_we = (wr_idx == '0);
          end
        end
        etpp_pkg::CMD_COMMIT: begin
          if (pend_q) begin
            rejected = 1'b1;
          end else begin
            cnt_d[target] = cnt_cl9[CNT_W-1:0];
            len_d[target] = len_cl25[LEN_W-1:0];
            if (run_q) begin
              pend_d = 1'b1;
            end else begin
              bank_d = target;
              run_d  = 1'b1;
              pos_d  = '0;
              ne_d   = '0;
              if (head0_q[target].off == '0) begin
                lev_d   = head0_q[target].lev;
                ne_d    = CNT_W'(1);
                applied = 1'b1;
              end
            end
          end
        end
        default: begin
          if (run_q) begin
            if (ne_q >= cnt_q[bank_q] && pos_n >= len_q[bank_q]) begin
              wrapped = 1'b1;
              pos_n   = '0;
              ne_d    = '0;
              if (pend_q) begin
                bank_d = ~bank_q;
                pend_d = 1'b0;
              end
            end
            pos_d = pos_n[OFFSET_BITS] ? '1 : pos_n[OFFSET_BITS-1:0];
            cand  = (ne_d == '0) ? head0_q[bank_d] : rd_q;
            if (ne_d < cnt_q[bank_d] && cand.off <= pos_d) begin
              lev_d   = cand.lev;
              ne_d    = ne_d + CNT_W'(1);
              applied = 1'b1;
            end
          end
        end
      endcase
    end
  end

  assign lev_out = 8'(lev_d);
  assign result_o = '{level_mask:    lev_out[etpp_pkg::LEVEL_W-1:0],
                      edge_applied:  applied,
                      cycle_wrapped: wrapped,
                      rejected:      rejected};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
    if (head_we) begin
      head0_q[target] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '{default: '0};
      len_q  <= '{default: LEN_W'(1)};
      bank_q <= 1'b0;
      pend_q <= 1'b0;
      run_q  <= 1'b0;
      ne_q   <= '0;
      pos_q  <= '0;
      lev_q  <= '0;
    end else begin
      cnt_q  <= cnt_d;
      len_q  <= len_d;
      bank_q <= bank_d;
      pend_q <= pend_d;
      run_q  <= run_d;
      ne_q   <= ne_d;
      pos_q  <= pos_d;
      lev_q  <= lev_d;
    end
  end

  a_run_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |=> run_q) else $error("engine stopped after start");

  a_pend_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> run_q) else $error("swap pending while engine idle");

  a_edge_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> ne_q <= cnt_q[bank_q]) else $error("edge index beyond bank count");

  a_reject_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && result_o.rejected) |-> pend_q) else $error("reject without pending swap");

  a_wrap_resets_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && result_o.cycle_wrapped) |=> pos_q == '0)
    else $error("position not cleared on wrap");

endmodule

/* rtl/edge_table_pwm_player.sv */
// ----------------------------------------------------------------------------
// edge_table_pwm_player
// Multichannel PWM player for a double-buffered table of edges.
// ----------------------------------------------------------------------------
// One result per transaction, one transaction per clock: an item is taken at
// every edge while the two-entry result queue has room, and its result is
// registered into that queue. item_stall_o is driven from the queue fill alone.
// The bound comes from the edge RAM: it is read once per cycle at the edge
// index that the current item leaves behind, so the following tick finds its
// edge ready; edge 0 of each bank sits in registers so that a starting commit
// or a wrap applies it on the same tick. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module edge_table_pwm_player #(
  parameter int unsigned MAX_EDGES   = etpp_pkg::MAX_EDGES_DEF,
  parameter int unsigned CHANNELS    = etpp_pkg::CHANNELS_DEF,
  parameter int unsigned OFFSET_BITS = etpp_pkg::OFFSET_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  output logic              item_stall_o,
  input  etpp_pkg::item_t   item_i,
  output logic              result_valid_o,
  input  logic              result_stall_i,
  output etpp_pkg::result_t result_o
);

  logic              accept;
  logic              pop;
  etpp_pkg::result_t res;
  etpp_pkg::result_t slot_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        fill_q;

  etpp_engine #(
    .MAX_EDGES   (MAX_EDGES),
    .CHANNELS    (CHANNELS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item_i),
    .result_o (res)
  );

  assign item_stall_o   = (fill_q == 2'd2);
  assign accept         = item_valid_i && !item_stall_o;
  assign result_valid_o = (fill_q != 2'd0);
  assign pop            = result_valid_o && !result_stall_i;
  assign result_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      fill_q <= fill_q + 2'(accept) - 2'(pop);
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != 2'd3) else $error("result queue overflow");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == 2'd0 || fill_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers out of step");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !pop) |=> fill_q == $past(fill_q) + 2'd1)
    else $error("queue fill not incremented");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the edge table PWM player. Each accepted input
// transaction runs through a behavioral copy of the player: both edge banks,
// swap logic, tick position and levels. The expected output is queued and
// compared field by field with the result stream. A short directed table comes
// first. It is followed by random bank loads, commits, ticks and rejected
// traffic under varying backpressure, and then a cycle whose late edges run
// past its length before the wrap.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CMD_W  = etpp_pkg::CMD_W;
  localparam int unsigned IDX_W  = etpp_pkg::INDEX_W;
  localparam int unsigned OFS_W  = etpp_pkg::OFFSET_W;
  localparam int unsigned LEV_W  = etpp_pkg::LEVEL_W;
  localparam int unsigned CNT_W  = etpp_pkg::COUNT_W;
  localparam int unsigned LEN_W  = etpp_pkg::LENGTH_W;

  localparam logic [CMD_W-1:0] CMD_TICK_ALT = 2'd3;
  localparam int unsigned NUM_EDGES   = etpp_pkg::MAX_EDGES_DEF;
  localparam int unsigned MAX_LEN     = 1 << etpp_pkg::OFFSET_BITS_DEF;
  localparam int unsigned POS_MAX     = MAX_LEN - 1;
  localparam int unsigned PHASE_ITEMS = 160;
  localparam int unsigned HOLD_CYCLES = 64;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned LATE_OFFSET = 40;
  localparam int unsigned LATE_LENGTH = 8;
  localparam int unsigned LONG_TICKS  = 48;

  typedef struct {
    etpp_pkg::item_t   stim;
    bit                typed;
    etpp_pkg::result_t want;
  } dir_row_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              item_valid_i   = 1'b0;
  logic              item_stall_o;
  etpp_pkg::item_t   item_i         = '0;
  logic              result_valid_o;
  logic              result_stall_i = 1'b0;
  etpp_pkg::result_t result_o;

  // player shadow state
  logic [OFS_W-1:0] tbl_offset [2][NUM_EDGES] = '{default: '0};
  logic [LEV_W-1:0] tbl_level  [2][NUM_EDGES] = '{default: '0};
  logic [CNT_W-1:0] tbl_count  [2] = '{default: '0};
  logic [LEN_W-1:0] tbl_length [2] = '{default: 17'd1};
  logic             play_bank  = 1'b0;
  logic             swap_armed = 1'b0;
  logic             engine_on  = 1'b0;
  logic [CNT_W-1:0] edge_ptr   = '0;
  logic [OFS_W-1:0] tick_pos   = '0;
  logic [LEV_W-1:0] out_levels = '0;

  etpp_pkg::result_t expected_outputs[$];
  int unsigned items_sent = 0;
  int unsigned n_err      = 0;
  int unsigned tx_pct     = 0;
  int unsigned rx_pct     = 0;
  bit          hold_start = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned quiet      = 0;

  edge_table_pwm_player dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_valid_i),
    .item_stall_o   (item_stall_o),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_stall_i (result_stall_i),
    .result_o       (result_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic fire_due_edge();
    if (edge_ptr >= tbl_count[play_bank] || edge_ptr >= NUM_EDGES) return 1'b0;
    if (tbl_offset[play_bank][edge_ptr[IDX_W-1:0]] > tick_pos) return 1'b0;
    out_levels = tbl_level[play_bank][edge_ptr[IDX_W-1:0]];
    edge_ptr++;
    return 1'b1;
  endfunction

  function automatic etpp_pkg::result_t advance_player(etpp_pkg::item_t it);
    etpp_pkg::result_t res;
    logic              target;
    logic [CNT_W-1:0]  cnt;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  pos;
    res = '0;
    target = ~play_bank;
    case (it.command)
      etpp_pkg::CMD_WRITE: begin
        if (swap_armed) begin
          res.rejected = 1'b1;
        end else begin
          tbl_offset[target][it.entry_index] = it.entry_offset;
          tbl_level[target][it.entry_index]  = it.entry_levels;
        end
      end
      etpp_pkg::CMD_COMMIT: begin
        if (swap_armed) begin
          res.rejected = 1'b1;
        end else begin
          cnt = it.edge_count;
          if (cnt == '0) cnt = CNT_W'(1);
          if (cnt > NUM_EDGES) cnt = CNT_W'(NUM_EDGES);
          len = it.cycle_length;
          if (len == '0) len = LEN_W'(1);
          if (len > MAX_LEN) len = LEN_W'(MAX_LEN);
          tbl_count[target]  = cnt;
          tbl_length[target] = len;
          if (engine_on) begin
            swap_armed = 1'b1;
          end else begin
            play_bank = target;
            engine_on = 1'b1;
            tick_pos  = '0;
            edge_ptr  = '0;
            res.edge_applied = fire_due_edge();
          end
        end
      end
      default: begin
        if (engine_on) begin
          pos = {1'b0, tick_pos} + LEN_W'(1);
          if (edge_ptr >= tbl_count[play_bank] && pos >= tbl_length[play_bank]) begin
            res.cycle_wrapped = 1'b1;
            pos = '0;
            edge_ptr = '0;
            if (swap_armed) begin
              play_bank  = ~play_bank;
              swap_armed = 1'b0;
            end
          end
          if (pos > POS_MAX) pos = LEN_W'(POS_MAX);
          tick_pos = pos[OFS_W-1:0];
          res.edge_applied = fire_due_edge();
        end
      end
    endcase
    res.level_mask = out_levels;
    return res;
  endfunction

  function automatic etpp_pkg::item_t rand_item(logic [CMD_W-1:0] cmd);
    logic [63:0]     bits;
    etpp_pkg::item_t it;
    bits = {$urandom(), $urandom()};
    it = bits[$bits(etpp_pkg::item_t)-1:0];
    it.command = cmd;
    return it;
  endfunction

  function automatic etpp_pkg::item_t any_tick();
    return rand_item(($urandom_range(3) == 0) ? CMD_TICK_ALT : etpp_pkg::CMD_TICK);
  endfunction

  function automatic dir_row_t row(logic [CMD_W-1:0] cmd, int unsigned idx,
                                   int unsigned ofs, int unsigned lev, int unsigned cnt,
                                   int unsigned len, bit typed = 1'b0,
                                   etpp_pkg::result_t want = '0);
    dir_row_t r;
    r.stim.command      = cmd;
    r.stim.entry_index  = IDX_W'(idx);
    r.stim.entry_offset = OFS_W'(ofs);
    r.stim.entry_levels = LEV_W'(lev);
    r.stim.edge_count   = CNT_W'(cnt);
    r.stim.cycle_length = LEN_W'(len);
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  task automatic flag_mismatch(string what);
    $display("%0t mismatch: %0s", $realtime, what);
    n_err++;
  endtask

  task automatic send(etpp_pkg::item_t it, bit typed = 1'b0,
                      etpp_pkg::result_t want = '0);
    etpp_pkg::result_t predicted;
    while ($urandom_range(99) < tx_pct) begin
      item_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    item_valid_i <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (item_stall_o);
    predicted = advance_player(it);
    expected_outputs.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic wait_results();
    item_valid_i <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk_i);
  endtask

  // writes slots 0..n-1 of the idle bank, then commits (sometimes abandoned)
  task automatic load_bank();
    etpp_pkg::item_t it;
    int unsigned     n;
    int unsigned     ofs;
    n = ($urandom_range(15) == 0) ? NUM_EDGES : $urandom_range(1, 6);
    ofs = 0;
    for (int k = 0; k < n; k++) begin
      it = rand_item(etpp_pkg::CMD_WRITE);
      it.entry_index = IDX_W'(k);
      if ($urandom_range(3) == 0) ofs = $urandom_range(12);
      else ofs += $urandom_range(3);
      it.entry_offset = OFS_W'(ofs);
      send(it);
      if ($urandom_range(7) == 0) send(any_tick());
    end
    if ($urandom_range(9) == 0) return;
    it = rand_item(etpp_pkg::CMD_COMMIT);
    if (n == NUM_EDGES) it.edge_count = CNT_W'($urandom_range(NUM_EDGES, 127));
    else if ($urandom_range(5) == 0) it.edge_count = CNT_W'($urandom_range(n));
    else it.edge_count = CNT_W'(n);
    it.cycle_length = LEN_W'($urandom_range(24));
    send(it);
  endtask

  task automatic run_random(int unsigned goal);
    while (items_sent < goal) begin
      if (swap_armed) begin
        if ($urandom_range(4) == 0)
          send(rand_item($urandom_range(1) ? etpp_pkg::CMD_WRITE : etpp_pkg::CMD_COMMIT));
        else send(any_tick());
      end else if ($urandom_range(3) != 0) begin
        load_bank();
      end else begin
        send(rand_item($urandom_range(1) ? etpp_pkg::CMD_WRITE : etpp_pkg::CMD_TICK));
      end
    end
  endtask

  always @(posedge clk_i) begin : result_side
    etpp_pkg::result_t want;
    if (rst_ni && result_valid_o && !result_stall_i) begin
      if (expected_outputs.size() == 0) begin
        flag_mismatch("result transaction with nothing expected");
      end else begin
        want = expected_outputs.pop_front();
        if (result_o.level_mask != want.level_mask)
          flag_mismatch($sformatf("level_mask %h, want %h", result_o.level_mask,
                                  want.level_mask));
        if (result_o.edge_applied != want.edge_applied)
          flag_mismatch($sformatf("edge_applied %b, want %b", result_o.edge_applied,
                                  want.edge_applied));
        if (result_o.cycle_wrapped != want.cycle_wrapped)
          flag_mismatch($sformatf("cycle_wrapped %b, want %b", result_o.cycle_wrapped,
                                  want.cycle_wrapped));
        if (result_o.rejected != want.rejected)
          flag_mismatch($sformatf("rejected %b, want %b", result_o.rejected,
                                  want.rejected));
      end
    end
    if (hold_start) begin
      hold_start = 1'b0;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      result_stall_i <= 1'b1;
    end else begin
      result_stall_i <= ($urandom_range(99) < rx_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (item_valid_i && !item_stall_o) || (result_valid_o && !result_stall_i))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("[edge_table_pwm_player] ERROR");
      $finish;
    end
  end

  initial begin
    dir_row_t        rows[$];
    etpp_pkg::item_t it;
    rows.push_back(row(etpp_pkg::CMD_TICK,   0, 0, 0, 0, 0, 1'b1));
    rows.push_back(row(CMD_TICK_ALT, 63, 16'hFFFF, 5'h1F, 127, 17'h1FFFF, 1'b1));
    rows.push_back(row(etpp_pkg::CMD_WRITE,  0, 0,         5'h1F, 0, 0, 1'b1));
    rows.push_back(row(etpp_pkg::CMD_WRITE,  1, 2,         5'h0A, 0, 0, 1'b1));
    rows.push_back(row(etpp_pkg::CMD_WRITE,  2, 2,         5'h15, 0, 0, 1'b1));
    rows.push_back(row(etpp_pkg::CMD_WRITE,  63, 16'hFFFF, 5'h00, 0, 0, 1'b1));
    rows.push_back(row(etpp_pkg::CMD_COMMIT, 0, 0, 0, 3, 4, 1'b1,
                       etpp_pkg::result_t'{5'h1F, 1'b1, 1'b0, 1'b0}));
    repeat (4) rows.push_back(row(etpp_pkg::CMD_TICK, 0, 0, 0, 0, 0));
    rows.push_back(row(etpp_pkg::CMD_WRITE,  0, 1, 5'h03, 0, 0));
    rows.push_back(row(etpp_pkg::CMD_COMMIT, 0, 0, 0, 0, 0));
    rows.push_back(row(etpp_pkg::CMD_WRITE,  5, 16'hABCD, 5'h1F, 0, 0));
    rows.push_back(row(etpp_pkg::CMD_COMMIT, 63, 16'hFFFF, 5'h1F, 127, 17'h1FFFF));
    rows.push_back(row(CMD_TICK_ALT, 0, 0, 0, 0, 0));
    repeat (4) rows.push_back(row(etpp_pkg::CMD_TICK, 0, 0, 0, 0, 0));
    rows.push_back(row(etpp_pkg::CMD_COMMIT, 0, 0, 0, 2, 1));
    repeat (4) rows.push_back(row(etpp_pkg::CMD_TICK, 0, 0, 0, 0, 0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_pct = 37;
    rx_pct = 62;
    foreach (rows[i]) send(rows[i].stim, rows[i].typed, rows[i].want);
    run_random(items_sent + PHASE_ITEMS);
    wait_results();

    tx_pct = 62;
    rx_pct = 37;
    run_random(items_sent + PHASE_ITEMS);
    wait_results();

    tx_pct = 0;
    rx_pct = 0;
    hold_start = 1'b1;
    run_random(items_sent + PHASE_ITEMS);
    wait_results();

    // late edges well past the cycle length, then the wrap
    while (swap_armed) send(any_tick());
    it = rand_item(etpp_pkg::CMD_WRITE);
    it.entry_index  = '0;
    it.entry_offset = '0;
    send(it);
    for (int k = 1; k < 3; k++) begin
      it = rand_item(etpp_pkg::CMD_WRITE);
      it.entry_index  = IDX_W'(k);
      it.entry_offset = OFS_W'(LATE_OFFSET);
      send(it);
    end
    it = rand_item(etpp_pkg::CMD_COMMIT);
    it.edge_count   = CNT_W'(3);
    it.cycle_length = LEN_W'(LATE_LENGTH);
    send(it);
    repeat (LONG_TICKS) send(any_tick());

    wait_results();
    repeat (8) @(posedge clk_i);
    if (n_err == 0) begin
      $display("[edge_table_pwm_player] OK");
    end else begin
      $display("[edge_table_pwm_player] ERROR");
    end
    $finish;
  end

endmodule
